/* hw/rtl/wsd_pkg.sv */
// shared types and constants for the window stability detector
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int DATA_W     = 16;
    localparam int BAND_W     = 16;
    localparam int WINDOW_LEN = 5;
    localparam int MISS_LIMIT = 3;

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int MISS_W = $clog2(MISS_LIMIT + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN) + 1;
    localparam int MAG_W  = SUM_W;
    localparam int STEP_W = $clog2(MAG_W + 1);
    localparam int CMP_W  = DATA_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     clr;
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
    } t_win_cmd;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

/* hw/rtl/window_stability_detector.sv */
// window stability detector: band check, window sum and iterative average
// accepted sample: band check, 5 adds, divider start, 20 quotient bits, done and
// output load in that order; the next request is taken only after the output load
// rejected sample: band check, then output load; next request taken only after it
// a result held with m_axis_tready low stalls the next one in the done state
// synchronous active-low reset clears window, average, counters and band
`timescale 1ns / 1ps

module window_stability_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [wsd_pkg::DATA_W-1:0] s_axis_tdata,   // [15:0] sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [wsd_pkg::DATA_W-1:0] m_axis_tdata,   // [15:0] average
    output logic                       m_axis_tuser,   // [0] stable
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wsd_pkg::BAND_W-1:0] i_cfg_data     // [15:0] band_half_width
);

    wsd_pkg::t_state r_state, n_state;

    logic signed [wsd_pkg::DATA_W-1:0] r_sample, n_sample;
    logic [wsd_pkg::BAND_W-1:0]        r_band;
    logic signed [wsd_pkg::DATA_W-1:0] r_avg, n_avg;
    logic [wsd_pkg::CNT_W-1:0]         r_count, n_count;
    logic [wsd_pkg::IDX_W-1:0]         r_wr_idx, n_wr_idx;
    logic [wsd_pkg::MISS_W-1:0]        r_miss, n_miss;
    logic                              r_stable, n_stable;
    logic [wsd_pkg::IDX_W-1:0]         r_sum_idx, n_sum_idx;
    logic signed [wsd_pkg::SUM_W-1:0]  r_acc, n_acc;
    logic                              r_out_valid, n_out_valid;
    logic signed [wsd_pkg::DATA_W-1:0] r_out_avg, n_out_avg;
    logic                              r_out_stable, n_out_stable;

    wsd_pkg::t_win_cmd                 win_cmd;
    logic signed [wsd_pkg::DATA_W-1:0] win_rd;
    wsd_pkg::t_div_req                 div_req;
    logic                              div_done;
    logic [wsd_pkg::MAG_W-1:0]         div_quo;

    logic signed [wsd_pkg::CMP_W-1:0]   s_ext, band_lo, band_hi;
    logic                               in_band;
    logic [wsd_pkg::MISS_W-1:0]         miss_inc;
    logic signed [wsd_pkg::SUM_W:0]     quo_signed;
    logic signed [wsd_pkg::DATA_W-1:0]  quo_sat;

    wsd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (win_cmd),
        .i_rd_idx  (r_sum_idx),
        .o_rd_data (win_rd)
    );

    wsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign s_axis_tready = (r_state == wsd_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_avg;
    assign m_axis_tuser  = r_out_stable;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        s_ext    = wsd_pkg::CMP_W'(r_sample);
        band_lo  = wsd_pkg::CMP_W'(r_avg) - $signed({2'b00, r_band});
        band_hi  = wsd_pkg::CMP_W'(r_avg) + $signed({2'b00, r_band});
        in_band  = (s_ext < band_hi) && (s_ext > band_lo);
        miss_inc = r_miss + 1'b1;

        if (r_acc[wsd_pkg::SUM_W-1]) begin
            quo_signed = -$signed({1'b0, div_quo});
        end else begin
            quo_signed = $signed({1'b0, div_quo});
        end
        if (quo_signed > (wsd_pkg::SUM_W+1)'(32767)) begin
            quo_sat = 16'sh7fff;
        end else if (quo_signed < -(wsd_pkg::SUM_W+1)'(32768)) begin
            quo_sat = -16'sh8000;
        end else begin
            quo_sat = quo_signed[wsd_pkg::DATA_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sample     = r_sample;
        n_avg        = r_avg;
        n_count      = r_count;
        n_wr_idx     = r_wr_idx;
        n_miss       = r_miss;
        n_stable     = r_stable;
        n_sum_idx    = r_sum_idx;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid;
        n_out_avg    = r_out_avg;
        n_out_stable = r_out_stable;

        win_cmd       = '0;
        win_cmd.wdata = r_sample;
        div_req       = '0;
        div_req.divisor = r_count;
        if (r_acc[wsd_pkg::SUM_W-1]) begin
            div_req.dividend = wsd_pkg::MAG_W'(-r_acc);
        end else begin
            div_req.dividend = wsd_pkg::MAG_W'(r_acc);
        end

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wsd_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sample = s_axis_tdata;
                    n_state  = wsd_pkg::S_CHECK;
                end
            end
            wsd_pkg::S_CHECK: begin
                if (in_band) begin
                    n_stable      = (r_count > wsd_pkg::CNT_W'(1));
                    if (r_count < wsd_pkg::CNT_W'(wsd_pkg::WINDOW_LEN)) begin
                        n_count = r_count + 1'b1;
                    end
                    win_cmd.we    = 1'b1;
                    win_cmd.waddr = r_wr_idx;
                    if (r_wr_idx == wsd_pkg::IDX_W'(wsd_pkg::WINDOW_LEN - 1)) begin
                        n_wr_idx = '0;
                    end else begin
                        n_wr_idx = r_wr_idx + 1'b1;
                    end
                    n_miss    = '0;
                    n_sum_idx = '0;
                    n_acc     = '0;
                    n_state   = wsd_pkg::S_SUM;
                end else begin
                    n_stable = 1'b0;
                    n_state  = wsd_pkg::S_DONE;
                    if (miss_inc >= wsd_pkg::MISS_W'(wsd_pkg::MISS_LIMIT)) begin
                        win_cmd.clr   = 1'b1;
                        win_cmd.we    = 1'b1;
                        win_cmd.waddr = '0;
                        n_count       = wsd_pkg::CNT_W'(1);
                        n_miss        = '0;
                        n_avg         = r_sample;
                        n_wr_idx      = wsd_pkg::IDX_W'(1 % wsd_pkg::WINDOW_LEN);
                    end else begin
                        n_miss = miss_inc;
                    end
                end
            end
            wsd_pkg::S_SUM: begin
                // shared adder walks the window one entry per cycle
                n_acc = r_acc + wsd_pkg::SUM_W'(win_rd);
                if (r_sum_idx == wsd_pkg::IDX_W'(wsd_pkg::WINDOW_LEN - 1)) begin
                    n_state = wsd_pkg::S_DIV_GO;
                end else begin
                    n_sum_idx = r_sum_idx + 1'b1;
                end
            end
            wsd_pkg::S_DIV_GO: begin
                div_req.start = 1'b1;
                n_state       = wsd_pkg::S_DIV;
            end
            wsd_pkg::S_DIV: begin
                if (div_done) begin
                    n_avg   = quo_sat;
                    n_state = wsd_pkg::S_DONE;
                end
            end
            wsd_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_avg    = r_avg;
                    n_out_stable = r_stable;
                    n_state      = wsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsd_pkg::S_IDLE;
            r_band      <= '0;
            r_avg       <= '0;
            r_count     <= '0;
            r_wr_idx    <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avg       <= n_avg;
            r_count     <= n_count;
            r_wr_idx    <= n_wr_idx;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_band <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample     <= n_sample;
        r_stable     <= n_stable;
        r_sum_idx    <= n_sum_idx;
        r_acc        <= n_acc;
        r_out_avg    <= n_out_avg;
        r_out_stable <= n_out_stable;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wsd_pkg::CNT_W'(wsd_pkg::WINDOW_LEN))
        else $error("accepted count above window length");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx < wsd_pkg::IDX_W'(wsd_pkg::WINDOW_LEN))
        else $error("write index outside window");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == wsd_pkg::S_DIV))
        else $error("divider finished outside divide state");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == wsd_pkg::S_CHECK))
        else $error("request not followed by band check");

    a_miss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss < wsd_pkg::MISS_W'(wsd_pkg::MISS_LIMIT))
        else $error("miss count reached limit without reseed");
`endif

endmodule

/* hw/rtl/wsd_window.sv */
// sample window store with one write port, one read port and a clear
`timescale 1ns / 1ps

module wsd_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wsd_pkg::t_win_cmd                 i_cmd,
    input  logic [wsd_pkg::IDX_W-1:0]         i_rd_idx,
    output logic signed [wsd_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [wsd_pkg::DATA_W-1:0] r_entry [wsd_pkg::WINDOW_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wsd_pkg::WINDOW_LEN; k++) begin
                r_entry[k] <= '0;
            end
        end else begin
            if (i_cmd.clr) begin
                for (int k = 0; k < wsd_pkg::WINDOW_LEN; k++) begin
                    r_entry[k] <= '0;
                end
            end
            if (i_cmd.we) begin
                r_entry[i_cmd.waddr] <= i_cmd.wdata;
            end
        end
    end

    assign o_rd_data = r_entry[i_rd_idx];

endmodule

/* hw/rtl/wsd_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wsd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wsd_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [wsd_pkg::MAG_W-1:0] o_quotient
);

    logic [wsd_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic [wsd_pkg::MAG_W-1:0]  r_quo, n_quo;
    logic [wsd_pkg::CNT_W-1:0]  r_dvs, n_dvs;
    logic [wsd_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    logic [wsd_pkg::CNT_W:0]   shifted;
    logic [wsd_pkg::CNT_W+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[wsd_pkg::MAG_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_step = wsd_pkg::STEP_W'(wsd_pkg::MAG_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (diff[wsd_pkg::CNT_W+1]) begin
                n_rem = shifted[wsd_pkg::CNT_W-1:0];
                n_quo = {r_quo[wsd_pkg::MAG_W-2:0], 1'b0};
            end else begin
                n_rem = diff[wsd_pkg::CNT_W-1:0];
                n_quo = {r_quo[wsd_pkg::MAG_W-2:0], 1'b1};
            end
            n_step = r_step - 1'b1;
            if (r_step == wsd_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* test/window_stability_checker.sv */
// request monitor, band and window tracker and result comparison for the stability detector
`timescale 1ns / 1ps

module window_stability_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    input  logic                       i_s_ready,
    input  logic [wsd_pkg::DATA_W-1:0] i_s_data,
    input  logic                       i_m_valid,
    input  logic                       i_m_ready,
    input  logic [wsd_pkg::DATA_W-1:0] i_m_data,
    input  logic                       i_m_user,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [wsd_pkg::BAND_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import wsd_pkg::*;

    typedef struct packed {
        logic              stable;
        logic [DATA_W-1:0] average;
    } t_stab_result;

    int           win_buf [WINDOW_LEN];
    int           avg_now;
    int           acc_cnt;
    int           wr_idx;
    int           miss_cnt;
    int           band;
    int           fails;
    t_stab_result avg_expect_q [$];

    // updates the tracked window with one sample and returns the result it should produce
    function automatic t_stab_result track_sample(input logic [DATA_W-1:0] raw);
        t_stab_result res;
        int           smp;
        int           sum;
        int           quo;
        smp = $signed(raw);
        res.stable = 1'b0;
        if (smp < avg_now + band && smp > avg_now - band) begin
            res.stable = (acc_cnt > 1);
            if (acc_cnt < WINDOW_LEN) begin
                acc_cnt++;
            end
            win_buf[wr_idx] = smp;
            sum = 0;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                sum += win_buf[j];
            end
            quo = sum / acc_cnt;
            if (quo > 32767) begin
                quo = 32767;
            end else if (quo < -32768) begin
                quo = -32768;
            end
            avg_now = quo;
            wr_idx = (wr_idx + 1) % WINDOW_LEN;
            miss_cnt = 0;
        end else begin
            miss_cnt++;
            if (miss_cnt >= MISS_LIMIT) begin
                // too many misses in a row: restart the window from this sample
                for (int j = 0; j < WINDOW_LEN; j++) begin
                    win_buf[j] = 0;
                end
                win_buf[0] = smp;
                acc_cnt = 1;
                miss_cnt = 0;
                avg_now = smp;
                wr_idx = 1 % WINDOW_LEN;
            end
        end
        res.average = avg_now[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_stab_result want;
        if (!i_rst_n) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                win_buf[j] = 0;
            end
            avg_now = 0;
            acc_cnt = 0;
            wr_idx = 0;
            miss_cnt = 0;
            band = 0;
            avg_expect_q.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                if (avg_expect_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result: expected none, got stable %0b average %0d",
                             $time, i_m_user, $signed(i_m_data));
                end else begin
                    want = avg_expect_q.pop_front();
                    if (want.stable !== i_m_user || want.average !== i_m_data) begin
                        fails++;
                        $display("%0t mismatch: expected stable %0b average %0d,",
                                 $time, want.stable, $signed(want.average),
                                 " got stable %0b average %0d",
                                 i_m_user, $signed(i_m_data));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                band = i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                avg_expect_q.push_back(track_sample(i_s_data));
            end
        end
        o_fail_count <= fails;
        o_pending <= avg_expect_q.size();
    end

endmodule

/* test/tb.sv */
// testbench top for the window stability detector: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import wsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 180;
    localparam int PHASE_COUNT    = 8;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [BAND_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;

    always #5 i_clk = ~i_clk;

    window_stability_detector i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    window_stability_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_user     (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_sample(input logic [DATA_W-1:0] value);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_band(input logic [BAND_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side back-pressure in random bursts
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int band_val;
        int center;
        int spread;
        int roll;
        int left;
        int near;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 30;
        rx_stall_pct = 30;

        // band still zero from reset: all misses, every third one reseeds
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h0001);
        wait_drained();

        // widest band: everything lands inside
        write_band(16'hFFFF);
        repeat (4) send_sample(16'h7FFF);
        repeat (3) send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        wait_drained();

        // band of one: only an exact hit on the average is taken
        write_band(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h04D2);
        repeat (2) send_sample(16'h04D2);
        send_sample(16'h04D3);
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: band_val = 0;
                1: band_val = 65535;
                2: band_val = $urandom_range(1, 8);
                3: band_val = $urandom_range(16, 512);
                4: band_val = $urandom_range(512, 8192);
                5: band_val = $urandom_range(0, 65535);
                6: band_val = 65534;
                default: band_val = $urandom_range(32, 4096);
            endcase
            if (ph == PHASE_COUNT - 1) begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end else begin
                tx_idle_pct = 20 * $urandom_range(0, 2);
                rx_stall_pct = 20 * $urandom_range(0, 2);
            end
            write_band(band_val[BAND_W-1:0]);
            spread = band_val / 3;
            center = $signed(16'($urandom));
            left = PHASE_ITEMS;
            while (left > 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    // three random samples back to back; a run of misses reseeds the window
                    repeat (3) send_sample(16'($urandom));
                    left -= 3;
                end else if (roll < 12) begin
                    send_sample(16'($urandom));
                    left--;
                end else begin
                    if (roll < 15) begin
                        center = $signed(16'($urandom));
                    end
                    near = center + int'($urandom_range(0, 2 * spread)) - spread;
                    if (near > 32767) begin
                        near = 32767;
                    end else if (near < -32768) begin
                        near = -32768;
                    end
                    send_sample(near[DATA_W-1:0]);
                    left--;
                end
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_window.sv
hw/rtl/wsd_div.sv
hw/rtl/window_stability_detector.sv
test/window_stability_checker.sv
test/tb.sv
